/* src/bcd_attitude_frame_parser_assert.svh */
// Assertion macros used by the attitude frame parser checker.
// Depends on nothing; included by the checker file.
`ifndef BCD_ATTITUDE_FRAME_PARSER_ASSERT_SVH
`define BCD_ATTITUDE_FRAME_PARSER_ASSERT_SVH

// Implication checked in the same cycle.
`define BAP_ASSERT_NOW(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define BAP_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/bap_pkg.sv */
// Shared constants, types and the group decode function of the attitude frame parser.
// Depends on nothing; used by the framer, the decoder and the top level.
package bap_pkg;

  localparam logic [7:0] SYNC_BYTE          = 8'h68;
  localparam logic [7:0] CMD_ATTITUDE       = 8'h84;
  localparam logic [7:0] DEFAULT_LAST_RESET = 8'd14;
  localparam int         CAPTURE_BASE       = 3;
  localparam int         CAPTURE_DEPTH      = 10;
  localparam int         GROUP_BYTES        = 9;
  localparam int         VALUE_W            = 19;
  localparam int         MAG_W              = 18;
  localparam logic [3:0] SIGN_POS           = 4'h0;
  localparam logic [3:0] SIGN_NEG           = 4'h1;

  typedef struct packed {
    logic                             valid;
    logic [GROUP_BYTES-1:0][7:0]      data;
  } frame_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      bad;
  } group_t;

  function automatic group_t decode_group(input logic [7:0] b0, input logic [7:0] b1,
                                          input logic [7:0] b2);
    logic [MAG_W-1:0] mag;
    group_t           res;
    mag = MAG_W'(b0[3:0]) * MAG_W'(10000) + MAG_W'(b1[7:4]) * MAG_W'(1000)
        + MAG_W'(b1[3:0]) * MAG_W'(100) + MAG_W'(b2[7:4]) * MAG_W'(10)
        + MAG_W'(b2[3:0]);
    res.bad = 1'b0;
    unique case (b0[7:4])
      SIGN_POS: res.value = signed'({1'b0, mag});
      SIGN_NEG: res.value = -signed'({1'b0, mag});
      default: begin
        res.value = '0;
        res.bad   = 1'b1;
      end
    endcase
    return res;
  endfunction

endpackage

/* src/bcd_attitude_frame_parser.sv */
// Top level of the attitude frame parser: framer followed by the decode stage.
// Depends on bap_pkg, bap_framer and bap_decoder.
//
// The block takes one received byte per cycle and frames compass replies that
// start with the sync byte 0x68; byte 1 sets the last index, or a zero there
// keeps default_last_index, written through cfg_we and cfg_wdata and used from
// the next frame on. A frame whose byte 3 is 0x84 yields one request on the
// output channel once its closing byte is accepted, carried through the
// framer's frame register and then the decode stage's result register.
// Each stage holds its result only while the next cannot take it, so a new byte is accepted every cycle
// unless both registers hold results while out_stall is high.
module bcd_attitude_frame_parser (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [7:0]                             rx_byte,
  input  logic                                   cfg_we,
  input  logic [7:0]                             cfg_wdata,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bap_pkg::VALUE_W-1:0]     pitch_hundredths,
  output logic signed [bap_pkg::VALUE_W-1:0]     roll_hundredths,
  output logic signed [bap_pkg::VALUE_W-1:0]     heading_hundredths,
  output logic [2:0]                             sign_error
);

  bap_pkg::frame_t frame;
  logic            frame_ready;

  bap_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .frame       (frame),
    .frame_ready (frame_ready)
  );

  bap_decoder u_decoder (
    .clk                (clk),
    .rst                (rst),
    .frame              (frame),
    .frame_ready        (frame_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .pitch_hundredths   (pitch_hundredths),
    .roll_hundredths    (roll_hundredths),
    .heading_hundredths (heading_hundredths),
    .sign_error         (sign_error)
  );

endmodule

/* src/bap_framer.sv */
// Byte framer: tracks the frame index and length, captures bytes 3 to 12, and
// registers a completed attitude frame. Depends on bap_pkg.
module bap_framer (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output bap_pkg::frame_t     frame,
  input  logic                frame_ready
);

  logic [7:0]                                 default_last_index;
  logic [7:0]                                 byte_index;
  logic [7:0]                                 last_index;
  logic [bap_pkg::CAPTURE_DEPTH-1:0][7:0]     captured_bytes;
  logic [bap_pkg::CAPTURE_DEPTH-1:0][7:0]     captured_next;
  logic [7:0]                                 last_next;
  logic                                       in_accept;
  logic                                       is_sync;
  logic                                       drop;
  logic                                       done;
  logic                                       emit;

  assign in_stall  = frame.valid && !frame_ready;
  assign in_accept = in_valid && !in_stall;
  assign is_sync   = (byte_index == 8'd0) && (rx_byte == bap_pkg::SYNC_BYTE);
  assign drop      = (byte_index == 8'd0) && !is_sync;

  always_comb begin
    priority if (byte_index == 8'd0) begin
      last_next = default_last_index;
    end else if ((byte_index == 8'd1) && (rx_byte != 8'd0)) begin
      last_next = rx_byte;
    end else begin
      last_next = last_index;
    end
  end

  always_comb begin
    for (int i = 0; i < bap_pkg::CAPTURE_DEPTH; i++) begin
      if (is_sync) begin
        captured_next[i] = '0;
      end else if (byte_index == 8'(bap_pkg::CAPTURE_BASE + i)) begin
        captured_next[i] = rx_byte;
      end else begin
        captured_next[i] = captured_bytes[i];
      end
    end
  end

  assign done = !drop && (byte_index == last_next);
  assign emit = done && (captured_next[0] == bap_pkg::CMD_ATTITUDE);

  always_ff @(posedge clk) begin
    if (rst) begin
      default_last_index <= bap_pkg::DEFAULT_LAST_RESET;
      byte_index         <= '0;
      last_index         <= bap_pkg::DEFAULT_LAST_RESET;
      captured_bytes     <= '0;
      frame.valid        <= 1'b0;
    end else begin
      if (cfg_we) begin
        default_last_index <= cfg_wdata;
      end
      if (in_accept && !drop) begin
        captured_bytes <= captured_next;
        last_index     <= last_next;
        byte_index     <= done ? 8'd0 : byte_index + 8'd1;
      end
      if (!in_stall) begin
        frame.valid <= in_accept && emit;
      end
      if (in_accept && emit) begin
        frame.data <= captured_next[bap_pkg::CAPTURE_DEPTH-1:1];
      end
    end
  end

endmodule

/* src/bap_decoder.sv */
// Decode stage: turns the three sign-nibble BCD groups of a frame into signed
// hundredths and holds them in the result register. Depends on bap_pkg.
module bap_decoder (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bap_pkg::frame_t                        frame,
  output logic                                   frame_ready,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bap_pkg::VALUE_W-1:0]     pitch_hundredths,
  output logic signed [bap_pkg::VALUE_W-1:0]     roll_hundredths,
  output logic signed [bap_pkg::VALUE_W-1:0]     heading_hundredths,
  output logic [2:0]                             sign_error
);

  bap_pkg::group_t pitch_grp;
  bap_pkg::group_t roll_grp;
  bap_pkg::group_t heading_grp;
  logic            load;

  assign pitch_grp   = bap_pkg::decode_group(frame.data[0], frame.data[1], frame.data[2]);
  assign roll_grp    = bap_pkg::decode_group(frame.data[3], frame.data[4], frame.data[5]);
  assign heading_grp = bap_pkg::decode_group(frame.data[6], frame.data[7], frame.data[8]);

  assign frame_ready = !out_valid || !out_stall;
  assign load        = frame_ready && frame.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_ready) begin
      out_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pitch_hundredths   <= pitch_grp.value;
      roll_hundredths    <= roll_grp.value;
      heading_hundredths <= heading_grp.value;
      sign_error         <= {heading_grp.bad, roll_grp.bad, pitch_grp.bad};
    end
  end

endmodule

/* src/bap_checker.sv */
// Port-level checker for the attitude frame parser, bound to the top level.
// Depends on bap_pkg and bcd_attitude_frame_parser_assert.svh.
`include "bcd_attitude_frame_parser_assert.svh"

module bap_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [bap_pkg::VALUE_W-1:0]     pitch_hundredths,
  input logic signed [bap_pkg::VALUE_W-1:0]     roll_hundredths,
  input logic signed [bap_pkg::VALUE_W-1:0]     heading_hundredths,
  input logic [2:0]                             sign_error
);

  logic signed [bap_pkg::VALUE_W-1:0] max_mag;
  logic                               in_range;
  logic                               bad_zero;

  assign max_mag  = bap_pkg::VALUE_W'(166665);
  assign in_range = (pitch_hundredths <= max_mag) && (pitch_hundredths >= -max_mag)
                 && (roll_hundredths <= max_mag) && (roll_hundredths >= -max_mag)
                 && (heading_hundredths <= max_mag) && (heading_hundredths >= -max_mag);
  assign bad_zero = (!sign_error[0] || (pitch_hundredths == '0))
                 && (!sign_error[1] || (roll_hundredths == '0))
                 && (!sign_error[2] || (heading_hundredths == '0));

  `BAP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pitch_hundredths) && $stable(roll_hundredths) && $stable(heading_hundredths) && $stable(sign_error), "Stalled request changed")
  `BAP_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid, "Result valid right after reset")
  `BAP_ASSERT_NOW(a_values, clk, rst, out_valid, in_range && bad_zero, "Result value out of range or flagged value not zero")
  `BAP_ASSERT_NOW(a_latency, clk, rst, $rose(out_valid), $past(in_valid && !in_stall, 2), "Result without a byte accepted two cycles earlier")

endmodule

bind bcd_attitude_frame_parser bap_checker u_bap_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .pitch_hundredths   (pitch_hundredths),
  .roll_hundredths    (roll_hundredths),
  .heading_hundredths (heading_hundredths),
  .sign_error         (sign_error)
);

/* tb/bcd_attitude_frame_parser_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench for bcd_attitude_frame_parser: directed frames, back-pressure
// and random byte streams, with results predicted per accepted byte and checked in order.
// Depends on bap_pkg and the bcd_attitude_frame_parser RTL.
module bcd_attitude_frame_parser_test;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [bap_pkg::VALUE_W-1:0] hund_t;

  typedef struct packed {
    hund_t      pitch;
    hund_t      roll;
    hund_t      heading;
    logic [2:0] err;
  } attitude_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  hund_t pitch_hundredths;
  hund_t roll_hundredths;
  hund_t heading_hundredths;
  logic [2:0] sign_error;

  logic [7:0] cur_index;
  logic [7:0] frame_last;
  logic [7:0] def_last;
  logic [7:0] captured [bap_pkg::CAPTURE_DEPTH];
  attitude_t attitude_q [$];
  attitude_t want;

  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int seg_left = 0;
  int hold_left = 0;
  int holds_wanted = 0;
  int holds_done = 0;

  bcd_attitude_frame_parser dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pitch_hundredths(pitch_hundredths),
    .roll_hundredths(roll_hundredths),
    .heading_hundredths(heading_hundredths),
    .sign_error(sign_error)
  );

  always #1 clk = ~clk;

  function automatic void bcd_group(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, output hund_t val,
                                    output logic bad);
    int mag;
    mag = (int'(b0[3:0]) * 100 + int'(b1[7:4]) * 10 + int'(b1[3:0])) * 100
        + int'(b2[7:4]) * 10 + int'(b2[3:0]);
    bad = 1'b0;
    if (b0[7:4] == bap_pkg::SIGN_POS) begin
      val = hund_t'(mag);
    end else if (b0[7:4] == bap_pkg::SIGN_NEG) begin
      val = hund_t'(-mag);
    end else begin
      val = '0;
      bad = 1'b1;
    end
  endfunction

  task automatic track_frame_byte(input logic [7:0] b);
    attitude_t r;
    logic bad;
    int idx;
    idx = cur_index;
    if (idx == 0) begin
      if (b != bap_pkg::SYNC_BYTE) return;
      foreach (captured[i]) captured[i] = 8'h00;
      frame_last = def_last;
    end
    if (idx == 1 && b != 8'h00) frame_last = b;
    if (idx >= bap_pkg::CAPTURE_BASE && idx < bap_pkg::CAPTURE_BASE + bap_pkg::CAPTURE_DEPTH)
      captured[idx - bap_pkg::CAPTURE_BASE] = b;
    if (idx != frame_last) begin
      cur_index = 8'(idx + 1);
      return;
    end
    cur_index = 8'h00;
    if (captured[0] != bap_pkg::CMD_ATTITUDE) return;
    r.err = 3'b000;
    bcd_group(captured[1], captured[2], captured[3], r.pitch, bad);
    r.err[0] = bad;
    bcd_group(captured[4], captured[5], captured[6], r.roll, bad);
    r.err[1] = bad;
    bcd_group(captured[7], captured[8], captured[9], r.heading, bad);
    r.err[2] = bad;
    attitude_q.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        rx_byte <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    track_frame_byte(b);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (attitude_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_default_last(input logic [7:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    def_last = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [3:0] bcd_nib();
    if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, 9));
    return 4'($urandom_range(10, 15));
  endfunction

  function automatic logic [3:0] sign_nib();
    if ($urandom_range(0, 99) < 90) begin
      return $urandom_range(0, 1) ? bap_pkg::SIGN_NEG : bap_pkg::SIGN_POS;
    end
    return 4'($urandom_range(2, 15));
  endfunction

  function automatic int pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return $urandom_range(12, 14);
    if (p < 65) return (def_last <= 40) ? 0 : 12;
    if (p < 80) return $urandom_range(1, 11);
    if (p < 97) return $urandom_range(15, 40);
    return $urandom_range(0, 255);
  endfunction

  task automatic send_frame(input int len_sel, input bit cut);
    logic [7:0] fr [$];
    int last;
    int n;
    fr.push_back(bap_pkg::SYNC_BYTE);
    fr.push_back(8'(len_sel));
    fr.push_back(8'($urandom));
    fr.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : bap_pkg::CMD_ATTITUDE);
    for (int g = 0; g < 3; g++) begin
      fr.push_back({sign_nib(), bcd_nib()});
      fr.push_back({bcd_nib(), bcd_nib()});
      fr.push_back({bcd_nib(), bcd_nib()});
    end
    last = (len_sel == 0) ? int'(def_last) : len_sel;
    while (fr.size() < last + 1) fr.push_back(8'($urandom));
    n = cut ? $urandom_range(1, last) : last + 1;
    for (int i = 0; i < n; i++) send_byte(fr[i]);
  endtask

  task automatic check_field(input string what, input logic signed [31:0] exp_val,
                             input logic signed [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (attitude_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected request: expected none, got %0d %0d %0d err %0d", $time,
                 pitch_hundredths, roll_hundredths, heading_hundredths, sign_error);
      end else begin
        want = attitude_q.pop_front();
        check_field("pitch_hundredths", want.pitch, pitch_hundredths);
        check_field("roll_hundredths", want.roll, roll_hundredths);
        check_field("heading_hundredths", want.heading, heading_hundredths);
        check_field("sign_error", want.err, sign_error);
      end
    end
  end

  always @(posedge clk) begin
    if (holds_done < holds_wanted) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (seg_left > 0) begin
      seg_left--;
    end else begin
      seg_left = $urandom_range(0, 11);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("bcd_attitude_frame_parser_test: FAIL");
    $finish;
  end

  task automatic test_dropped_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(bap_pkg::SYNC_BYTE - 8'h01);
  endtask

  task automatic test_extreme_values();
    logic [7:0] fr [13] = '{bap_pkg::SYNC_BYTE, 8'h0C, 8'h5A, bap_pkg::CMD_ATTITUDE,
                            8'h1F, 8'hFF, 8'hFF, 8'h09, 8'h99, 8'h99,
                            8'hF5, 8'h55, 8'h55};
    foreach (fr[i]) send_byte(fr[i]);
  endtask

  task automatic test_short_and_foreign_frames();
    logic [7:0] ends_early [3] = '{bap_pkg::SYNC_BYTE, 8'h02, 8'h00};
    logic [7:0] foreign [4] = '{bap_pkg::SYNC_BYTE, 8'h03, 8'h00,
                                bap_pkg::CMD_ATTITUDE + 8'h01};
    logic [7:0] partial [6] = '{bap_pkg::SYNC_BYTE, 8'h05, 8'h00, bap_pkg::CMD_ATTITUDE,
                                8'h0F, 8'hFF};
    foreach (ends_early[i]) send_byte(ends_early[i]);
    foreach (foreign[i]) send_byte(foreign[i]);
    foreach (partial[i]) send_byte(partial[i]);
  endtask

  task automatic test_zero_default();
    wait_drained();
    write_default_last(8'h00);
    send_byte(bap_pkg::SYNC_BYTE);
    send_byte(bap_pkg::SYNC_BYTE);
    wait_drained();
    write_default_last(bap_pkg::DEFAULT_LAST_RESET);
  endtask

  task automatic test_backpressure();
    wait_drained();
    gap_max = 0;
    stall_pct = 0;
    holds_wanted++;
    for (int k = 0; k < 15; k++) send_frame(6, 1'b0);
    wait_drained();
  endtask

  task automatic run_phase(input logic [7:0] dflt, input int quota, input int gmax,
                           input int spct, input bit long_first);
    int start;
    int p;
    wait_drained();
    write_default_last(dflt);
    gap_max = gmax;
    stall_pct = spct;
    start = items_sent;
    if (long_first) send_frame(0, 1'b0);
    while (items_sent - start < quota) begin
      p = $urandom_range(0, 99);
      if (p < 80) begin
        send_frame(pick_len(), 1'b0);
      end else if (p < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        send_frame(pick_len(), 1'b1);
      end
    end
  endtask

  task automatic test_random_traffic();
    run_phase(bap_pkg::DEFAULT_LAST_RESET, 200, 4, 30, 1'b0);
    run_phase(8'd12, 200, 0, 0, 1'b0);
    run_phase(8'd1, 150, 2, 50, 1'b0);
    run_phase(8'd255, 300, 3, 20, 1'b1);
    run_phase(8'd13, 200, 6, 60, 1'b0);
    run_phase(8'($urandom_range(1, 255)), 200, 3, 40, 1'b0);
  endtask

  initial begin
    cur_index = 8'h00;
    def_last = bap_pkg::DEFAULT_LAST_RESET;
    frame_last = bap_pkg::DEFAULT_LAST_RESET;
    foreach (captured[i]) captured[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    gap_max = 2;
    stall_pct = 25;
    test_dropped_noise();
    test_extreme_values();
    test_short_and_foreign_frames();
    test_zero_default();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("bcd_attitude_frame_parser_test: PASS");
    end else begin
      $display("bcd_attitude_frame_parser_test: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bap_pkg.sv
src/bap_framer.sv
src/bap_decoder.sv
src/bcd_attitude_frame_parser.sv
src/bap_checker.sv
tb/bcd_attitude_frame_parser_test.sv
